/* sv/wasf_pkg.sv */
// ----------------------------------------------------------------------------
// wasf_pkg
// Shared types and constants for the weighted action selector: payload
// words, controller commands, datapath status and register indexes.
// ----------------------------------------------------------------------------
package wasf_pkg;

    localparam int NUM_INPUTS = 4;
    localparam int NUM_MOTORS = 8;
    localparam int IDX_W      = $clog2(NUM_MOTORS);
    localparam int TOTAL_W    = 35;

    localparam logic [31:0] WEIGHT_RESET  = 32'd1000;
    localparam logic [31:0] HALVE_LIMIT   = 32'h7FFF_FFFF;
    localparam logic [2:0]  INPUTS_RESET  = 3'd4;
    localparam logic [3:0]  MOTORS_RESET  = 4'd8;
    localparam logic [31:0] FADE_RESET    = 32'd1;
    localparam logic [31:0] FLOOR_RESET   = 32'd1000;

    // action codes of an input word
    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_REINFORCE = 1'b1;

    typedef enum logic [1:0] {
        CFG_INPUTS_IN_USE = 2'd0,
        CFG_MOTORS_IN_USE = 2'd1,
        CFG_FADE_STEP     = 2'd2,
        CFG_WEIGHT_FLOOR  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        action;
        logic [31:0] axon_in_0;
        logic [31:0] axon_in_1;
        logic [31:0] axon_in_2;
        logic [31:0] axon_in_3;
        logic [31:0] random_word;
        logic [31:0] reward_amount;
        logic        motor_active;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  chosen_index;
        logic [31:0] axon_level;
        logic [15:0] drive_out;
        logic        new_choice;
        logic        reinforced;
        logic        weights_halved;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic sum_step;
        logic tot_start;
        logic tot_step;
        logic mul;
        logic scan_start;
        logic scan_step;
        logic axon_upd;
        logic reinf;
        logic halve_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_reinf;
        logic sum_done;
        logic sel_go;
        logic idx_last_mo;
        logic idx_last_all;
        logic scan_hit;
        logic halve_go;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/wasf_ctrl.sv */
// ----------------------------------------------------------------------------
// wasf_ctrl
// Sequencer for one word at a time: input sum, weight total, draw scaling,
// roulette scan, axon update, reinforcement and the halving sweep.
// ----------------------------------------------------------------------------
module wasf_ctrl
    import wasf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_START = 12'b0000_0000_0010,
        S_SUM   = 12'b0000_0000_0100,
        S_CHECK = 12'b0000_0000_1000,
        S_TOTAL = 12'b0000_0001_0000,
        S_MUL   = 12'b0000_0010_0000,
        S_RND   = 12'b0000_0100_0000,
        S_SCAN  = 12'b0000_1000_0000,
        S_AXON  = 12'b0001_0000_0000,
        S_REINF = 12'b0010_0000_0000,
        S_HALVE = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_status.is_reinf ? S_REINF : S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.sel_go) begin
                    o_cmd.tot_start = 1'b1;
                    n_state         = S_TOTAL;
                end else begin
                    n_state = S_AXON;
                end
            end
            S_TOTAL: begin
                o_cmd.tot_step = 1'b1;
                if (i_status.idx_last_mo) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit || i_status.idx_last_mo) begin
                    n_state = S_AXON;
                end
            end
            S_AXON: begin
                o_cmd.axon_upd = 1'b1;
                n_state        = S_OUT;
            end
            S_REINF: begin
                o_cmd.reinf = 1'b1;
                n_state     = i_status.halve_go ? S_HALVE : S_OUT;
            end
            S_HALVE: begin
                o_cmd.halve_step = 1'b1;
                if (i_status.idx_last_all) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/wasf_dp.sv */
// ----------------------------------------------------------------------------
// wasf_dp
// Datapath: configuration registers, motor weights, axon and selection
// state, the shared step index, the draw multiplier and the result register.
// ----------------------------------------------------------------------------
module wasf_dp
    import wasf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_word    i_in_word,
    input  logic        i_out_stall,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_out_valid,
    output t_out_word   o_out_word
);

    // configuration
    logic [2:0]  r_inputs_in_use;
    logic [3:0]  r_motors_in_use;
    logic [31:0] r_fade_step;
    logic [31:0] r_floor;

    // state
    logic [31:0]      r_axon;
    logic [IDX_W-1:0] r_slot;
    logic [31:0]      r_weight [NUM_MOTORS];

    // working registers
    t_in_word           r_in;
    logic [IDX_W-1:0]   r_idx;
    logic [31:0]        r_sum;
    logic               r_all_active;
    logic [TOTAL_W-1:0] r_total;
    logic [63:0]        r_prod_lo;
    logic [TOTAL_W-1:0] r_prod_hi;
    logic [TOTAL_W-1:0] r_rnd;
    logic [TOTAL_W-1:0] r_run;
    logic               r_new_choice;
    logic               r_reinforced;
    logic               r_halved;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [31:0]        in_arr [NUM_INPUTS];
    logic [31:0]        cur_in;
    logic [31:0]        cur_w;
    logic [2:0]         n_in;
    logic [3:0]         n_mo;
    logic [IDX_W-1:0]   n_in_last;
    logic [IDX_W-1:0]   n_mo_last;
    logic [32:0]        n_sum_wide;
    logic [31:0]        n_sum;
    logic [TOTAL_W-1:0] n_rnd;
    logic [TOTAL_W-1:0] n_run;
    logic [32:0]        n_w_wide;
    logic [31:0]        n_w;
    logic [31:0]        n_half;
    logic               reinf_go;
    logic               w_over;
    logic               out_free;

    assign in_arr[0] = r_in.axon_in_0;
    assign in_arr[1] = r_in.axon_in_1;
    assign in_arr[2] = r_in.axon_in_2;
    assign in_arr[3] = r_in.axon_in_3;
    assign cur_in    = in_arr[r_idx[1:0]];
    assign cur_w     = r_weight[r_idx];

    // counts outside the supported range act as the nearest limit
    always_comb begin
        if (r_inputs_in_use == 3'd0) begin
            n_in = 3'd1;
        end else if (r_inputs_in_use > 3'(NUM_INPUTS)) begin
            n_in = 3'(NUM_INPUTS);
        end else begin
            n_in = r_inputs_in_use;
        end
        if (r_motors_in_use == 4'd0) begin
            n_mo = 4'd1;
        end else if (r_motors_in_use > 4'(NUM_MOTORS)) begin
            n_mo = 4'(NUM_MOTORS);
        end else begin
            n_mo = r_motors_in_use;
        end
    end

    assign n_in_last  = IDX_W'(n_in - 3'd1);
    assign n_mo_last  = IDX_W'(n_mo - 4'd1);

    assign n_sum_wide = {1'b0, r_sum} + {1'b0, cur_in};
    assign n_sum      = n_sum_wide[32] ? '1 : n_sum_wide[31:0];
    assign n_rnd      = r_prod_hi + TOTAL_W'(r_prod_lo[63:32]);
    assign n_run      = r_run + TOTAL_W'(cur_w);
    assign n_w_wide   = {1'b0, cur_w} + {1'b0, r_in.reward_amount};
    assign n_w        = n_w_wide[32] ? '1 : n_w_wide[31:0];
    assign n_half     = ({1'b0, cur_w[31:1]} < r_floor) ? r_floor : {1'b0, cur_w[31:1]};
    assign reinf_go   = (r_axon != '0) && r_in.motor_active;
    assign w_over     = n_w > HALVE_LIMIT;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        o_status              = '0;
        o_status.is_reinf     = r_in.action == ACT_REINFORCE;
        o_status.sum_done     = (cur_in == '0) || (r_idx == n_in_last);
        o_status.sel_go       = r_all_active && (r_axon == '0);
        o_status.idx_last_mo  = r_idx == n_mo_last;
        o_status.idx_last_all = r_idx == IDX_W'(NUM_MOTORS - 1);
        o_status.scan_hit     = n_run > r_rnd;
        o_status.halve_go     = reinf_go && w_over;
        o_status.out_free     = out_free;
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_in_use <= INPUTS_RESET;
            r_motors_in_use <= MOTORS_RESET;
            r_fade_step     <= FADE_RESET;
            r_floor         <= FLOOR_RESET;
            r_axon          <= '0;
            r_slot          <= '0;
            r_out_valid     <= 1'b0;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_weight[k] <= WEIGHT_RESET;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INPUTS_IN_USE: r_inputs_in_use <= i_cfg_data[2:0];
                    CFG_MOTORS_IN_USE: r_motors_in_use <= i_cfg_data[3:0];
                    CFG_FADE_STEP:     r_fade_step     <= i_cfg_data;
                    CFG_WEIGHT_FLOOR:  r_floor         <= i_cfg_data;
                endcase
            end
            if (i_cmd.scan_step && o_status.scan_hit) begin
                r_slot <= r_idx;
            end
            if (i_cmd.axon_upd) begin
                if (r_sum < r_axon) begin
                    r_axon <= (r_axon > r_fade_step) ? r_axon - r_fade_step : '0;
                end else begin
                    r_axon <= r_sum;
                end
            end
            if (i_cmd.reinf && reinf_go) begin
                r_weight[r_idx] <= n_w;
            end
            if (i_cmd.halve_step) begin
                r_weight[r_idx] <= n_half;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in         <= i_in_word;
            // reinforcement reads the selected slot through the step index
            r_idx        <= (i_in_word.action == ACT_REINFORCE) ? r_slot : '0;
            r_sum        <= '0;
            r_all_active <= 1'b1;
            r_new_choice <= 1'b0;
            r_reinforced <= 1'b0;
            r_halved     <= 1'b0;
        end
        if (i_cmd.sum_step) begin
            r_idx <= r_idx + 1'b1;
            if (cur_in == '0) begin
                r_all_active <= 1'b0;
            end else begin
                r_sum <= n_sum;
            end
        end
        if (i_cmd.tot_start) begin
            r_idx   <= '0;
            r_total <= '0;
        end
        if (i_cmd.tot_step) begin
            r_idx   <= r_idx + 1'b1;
            r_total <= r_total + TOTAL_W'(cur_w);
        end
        if (i_cmd.mul) begin
            r_prod_lo <= r_in.random_word * r_total[31:0];
            r_prod_hi <= TOTAL_W'(r_in.random_word) * TOTAL_W'(r_total[TOTAL_W-1:32]);
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
            r_run <= '0;
            r_rnd <= n_rnd;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            r_run <= n_run;
            if (o_status.scan_hit) begin
                r_new_choice <= 1'b1;
            end
        end
        if (i_cmd.reinf && reinf_go) begin
            r_reinforced <= 1'b1;
            if (w_over) begin
                r_halved <= 1'b1;
                r_idx    <= '0;
            end
        end
        if (i_cmd.halve_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.chosen_index   <= r_slot;
            r_out.axon_level     <= r_axon;
            r_out.drive_out      <= r_axon[15:0];
            r_out.new_choice     <= r_new_choice;
            r_out.reinforced     <= r_reinforced;
            r_out.weights_halved <= r_halved;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    // the scaled draw lands inside the wheel whenever the total weight is not zero
    a_rnd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_start && (r_total != '0)) |-> (n_rnd < r_total))
        else $error("scaled draw not below total weight");

    // a halved weight never drops under the floor
    a_halve_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.halve_step |=> (r_weight[$past(r_idx)] >= r_floor))
        else $error("halved weight below floor");

    // a fresh selection only happens while the axon is quiet
    a_pick_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && o_status.scan_hit) |-> (r_axon == '0))
        else $error("selection made with active axon");

    // the result register is only loaded once the previous word has gone
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

/* sv/weighted_action_selector_with_fading.sv */
// ----------------------------------------------------------------------------
// weighted_action_selector_with_fading
// Roulette-wheel motor selection with a fading axon and reinforcement of
// the selected weight, halving all weights when one grows too large.
//
//   channel   direction  handshake          payload
//   in        input      i_in_valid/o_in_stall    i_in_word  (t_in_word)
//   out       output     o_out_valid/i_out_stall  o_out_word (t_out_word)
//   cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// one word at a time, all steps run through a single weight read port
// tick word: input sum, then weight total, draw scaling and roulette scan for a draw, then axon update
// reinforce word: weight reinforcement, plus the halving sweep over every weight when it fires
// reset is synchronous, weights come out of reset at 1000 each
// a stalled result waits in the output register, the next word is taken meanwhile
// ----------------------------------------------------------------------------
module weighted_action_selector_with_fading
    import wasf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    wasf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wasf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

/* dv/wasf_checker.sv */
// ----------------------------------------------------------------------------
// wasf_checker
// Watches the input, output and register channels of the weighted action
// selector. Predicts every result word from its own copy of the axon, the
// selected slot, the motor weights and the settings, and compares it field
// by field with what the block delivers.
// ----------------------------------------------------------------------------
module wasf_checker
    import wasf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_err_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]  inputs_cfg;
    logic [3:0]  motors_cfg;
    logic [31:0] fade_cfg;
    logic [31:0] floor_cfg;

    logic [31:0] axon_q;
    logic [2:0]  slot_q;
    logic [31:0] weight_q [NUM_MOTORS];

    t_out_word   expected_words [$];

    function automatic int unsigned bound_count(int unsigned v, int unsigned hi);
        if (v < 1) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_err_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        o_err_count++;
    endtask

    task automatic reset_selector();
        inputs_cfg = INPUTS_RESET;
        motors_cfg = MOTORS_RESET;
        fade_cfg   = FADE_RESET;
        floor_cfg  = FLOOR_RESET;
        axon_q     = '0;
        slot_q     = '0;
        for (int k = 0; k < NUM_MOTORS; k++) begin
            weight_q[k] = WEIGHT_RESET;
        end
    endtask

    task automatic write_setting(input t_cfg_idx idx, input logic [31:0] data);
        case (idx)
            CFG_INPUTS_IN_USE: inputs_cfg = data[2:0];
            CFG_MOTORS_IN_USE: motors_cfg = data[3:0];
            CFG_FADE_STEP:     fade_cfg   = data;
            CFG_WEIGHT_FLOOR:  floor_cfg  = data;
            default: ;
        endcase
    endtask

    task automatic select_and_fade(input t_in_word w, output t_out_word r);
        logic [31:0] axons [NUM_INPUTS];
        int unsigned n_in;
        int unsigned n_mo;
        logic [32:0] sum;
        logic        all_on;
        logic        found;
        logic [34:0] total;
        logic [34:0] rnd;
        logic [34:0] run;
        logic [66:0] lhs;
        logic [66:0] rhs;
        logic [66:0] prod;
        logic [32:0] grown;
        logic [31:0] half;
        r = '0;
        if (w.action != ACT_REINFORCE) begin
            axons[0] = w.axon_in_0;
            axons[1] = w.axon_in_1;
            axons[2] = w.axon_in_2;
            axons[3] = w.axon_in_3;
            n_in = bound_count(inputs_cfg, NUM_INPUTS);
            n_mo = bound_count(motors_cfg, NUM_MOTORS);
            sum = '0;
            all_on = 1'b1;
            // sum stops at the first silent input and saturates at 32 bits
            for (int i = 0; i < n_in; i++) begin
                if (all_on) begin
                    if (axons[i] == '0) begin
                        all_on = 1'b0;
                    end else begin
                        sum = sum + axons[i];
                        if (sum[32]) begin
                            sum = 33'h0_FFFF_FFFF;
                        end
                    end
                end
            end
            if (all_on && axon_q == '0) begin
                total = '0;
                for (int i = 0; i < n_mo; i++) begin
                    total = total + weight_q[i];
                end
                lhs  = w.random_word;
                rhs  = total;
                prod = lhs * rhs;
                rnd  = prod[66:32];
                run  = '0;
                found = 1'b0;
                // roulette wheel: first slot whose running sum passes the draw
                for (int i = 0; i < n_mo; i++) begin
                    if (!found) begin
                        run = run + weight_q[i];
                        if (run > rnd) begin
                            slot_q = 3'(i);
                            r.new_choice = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (sum < {1'b0, axon_q}) begin
                axon_q = (axon_q > fade_cfg) ? axon_q - fade_cfg : '0;
            end else begin
                axon_q = sum[31:0];
            end
        end else if (axon_q != '0 && w.motor_active) begin
            grown = {1'b0, weight_q[slot_q]} + {1'b0, w.reward_amount};
            if (grown[32]) begin
                grown = 33'h0_FFFF_FFFF;
            end
            weight_q[slot_q] = grown[31:0];
            r.reinforced = 1'b1;
            if (grown[31:0] > HALVE_LIMIT) begin
                for (int k = 0; k < NUM_MOTORS; k++) begin
                    half = weight_q[k] >> 1;
                    weight_q[k] = (half < floor_cfg) ? floor_cfg : half;
                end
                r.weights_halved = 1'b1;
            end
        end
        r.chosen_index = slot_q;
        r.axon_level   = axon_q;
        r.drive_out    = axon_q[15:0];
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            reset_selector();
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(t_cfg_idx'(i_cfg_index), i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                select_and_fade(i_in_word, want);
                expected_words.insert(expected_words.size(), want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word with none expected, axon_level %h",
                                              got.axon_level));
                end else begin
                    want = expected_words.pop_front();
                    if (got.chosen_index !== want.chosen_index) begin
                        report_mismatch($sformatf("chosen_index got %0d expected %0d",
                                                  got.chosen_index, want.chosen_index));
                    end
                    if (got.axon_level !== want.axon_level) begin
                        report_mismatch($sformatf("axon_level got %h expected %h",
                                                  got.axon_level, want.axon_level));
                    end
                    if (got.drive_out !== want.drive_out) begin
                        report_mismatch($sformatf("drive_out got %h expected %h",
                                                  got.drive_out, want.drive_out));
                    end
                    if (got.new_choice !== want.new_choice) begin
                        report_mismatch($sformatf("new_choice got %b expected %b",
                                                  got.new_choice, want.new_choice));
                    end
                    if (got.reinforced !== want.reinforced) begin
                        report_mismatch($sformatf("reinforced got %b expected %b",
                                                  got.reinforced, want.reinforced));
                    end
                    if (got.weights_halved !== want.weights_halved) begin
                        report_mismatch($sformatf("weights_halved got %b expected %b",
                                                  got.weights_halved, want.weights_halved));
                    end
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the weighted action selector: a directed opening through
// selection, fading, saturation, halving down to a zero wheel and a slot
// outside the motors in use, then random episodes of strike, reinforce and
// fade words under several settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wasf_pkg::*;

    localparam int          CYCLE_LIMIT     = 500000;
    localparam int          ITEMS_PER_PHASE = 165;
    localparam int          RANDOM_PHASES   = 8;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_INPUTS_IN_USE;
    logic [31:0] cfg_data  = '0;

    int err_count;
    int pending;
    bit quiet       = 1'b0;
    int calm_words  = 0;
    int words_sent  = 0;
    int phase_start = 0;
    int cycle_count = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    weighted_action_selector_with_fading dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wasf_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls in bursts, with stall-free stretches now and then
    initial begin
        forever begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    function automatic t_in_word tick_word(input logic [31:0] a0, input logic [31:0] a1,
                                           input logic [31:0] a2, input logic [31:0] a3,
                                           input logic [31:0] draw);
        t_in_word w;
        w.action        = ACT_TICK;
        w.axon_in_0     = a0;
        w.axon_in_1     = a1;
        w.axon_in_2     = a2;
        w.axon_in_3     = a3;
        w.random_word   = draw;
        w.reward_amount = $urandom;
        w.motor_active  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_in_word reinforce_word(input logic [31:0] reward, input logic active);
        t_in_word w;
        w.action        = ACT_REINFORCE;
        w.axon_in_0     = $urandom;
        w.axon_in_1     = $urandom;
        w.axon_in_2     = $urandom;
        w.axon_in_3     = $urandom;
        w.random_word   = $urandom;
        w.reward_amount = reward;
        w.motor_active  = active;
        return w;
    endfunction

    // nonzero presynaptic level, small to near full scale
    function automatic logic [31:0] pick_level();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(1, 255);
            1: v = $urandom_range(1, 65535);
            2: v = $urandom;
            default: v = ALL_ONES - $urandom_range(0, 3);
        endcase
        return (v == '0) ? 32'd1 : v;
    endfunction

    function automatic logic [31:0] maybe_level();
        if ($urandom_range(0, 3) == 0) begin
            return '0;
        end
        return pick_level();
    endfunction

    function automatic logic [31:0] pick_draw();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_reward();
        case ($urandom_range(0, 5))
            0: return '0;
            1, 2: return $urandom_range(1, 5000);
            3: return $urandom;
            4: return 32'h8000_0000 + $urandom_range(0, 255);
            default: return ALL_ONES;
        endcase
    endfunction

    task automatic push_word(input t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (calm_words > 0) begin
            calm_words--;
        end else if (!quiet) begin
            if ($urandom_range(0, 29) == 0) begin
                calm_words = $urandom_range(20, 60);
            end else if ($urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] n_in, input logic [31:0] n_mo,
                              input logic [31:0] fade, input logic [31:0] floor_v);
        write_reg(CFG_INPUTS_IN_USE, n_in);
        write_reg(CFG_MOTORS_IN_USE, n_mo);
        write_reg(CFG_FADE_STEP, fade);
        write_reg(CFG_WEIGHT_FLOOR, floor_v);
    endtask

    // maybe fade the axon first, strike for a choice, reward it, then let it fade
    task automatic run_episode();
        t_in_word w;
        if ($urandom_range(0, 1) == 1) begin
            push_word(tick_word('0, $urandom, $urandom, $urandom, $urandom));
        end
        push_word(tick_word(pick_level(), pick_level(), pick_level(), pick_level(),
                            pick_draw()));
        repeat ($urandom_range(0, 3)) begin
            push_word(reinforce_word(pick_reward(), $urandom_range(0, 3) != 0));
        end
        repeat ($urandom_range(0, 3)) begin
            push_word(tick_word(maybe_level(), maybe_level(), maybe_level(), maybe_level(),
                                $urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
            w.action        = 1'($urandom_range(0, 1));
            w.axon_in_0     = $urandom;
            w.axon_in_1     = $urandom;
            w.axon_in_2     = $urandom;
            w.axon_in_3     = $urandom;
            w.random_word   = $urandom;
            w.reward_amount = $urandom;
            w.motor_active  = 1'($urandom_range(0, 1));
            push_word(w);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset: choice at the bottom of the wheel, rewards, fading
        push_word(tick_word(32'd1, 32'd2, 32'd3, 32'd4, '0));
        push_word(reinforce_word(32'd123, 1'b0));
        push_word(reinforce_word('0, 1'b1));
        push_word(reinforce_word(32'd5000, 1'b1));
        push_word(tick_word('0, 32'd9, 32'd9, 32'd9, $urandom));
        push_word(tick_word(32'd5, '0, 32'd7, 32'd8, $urandom));
        push_word(tick_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        push_word(tick_word(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0));
        drain();

        // top of the wheel, then halve everything else down to nothing
        write_reg(CFG_INPUTS_IN_USE, 32'd1);
        write_reg(CFG_FADE_STEP, ALL_ONES);
        write_reg(CFG_WEIGHT_FLOOR, '0);
        push_word(tick_word('0, '0, '0, '0, $urandom));
        push_word(tick_word(32'd1, '0, '0, '0, ALL_ONES));
        repeat (13) push_word(reinforce_word(ALL_ONES, 1'b1));
        drain();

        // empty wheel keeps the old choice, which now lies outside the motors in use
        write_reg(CFG_MOTORS_IN_USE, 32'd1);
        push_word(tick_word('0, $urandom, $urandom, $urandom, $urandom));
        push_word(tick_word(32'd5, $urandom, $urandom, $urandom, ALL_ONES));
        push_word(reinforce_word(32'd10, 1'b1));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet = (p == RANDOM_PHASES - 1);
            case (p)
                0: set_config(32'd4, 32'd8, 32'd1, 32'd1000);
                1: set_config(32'd1, 32'd1, '0, 32'd1);
                2: set_config('0, '0, ALL_ONES, ALL_ONES);
                3: set_config(32'd7, 32'd15, $urandom, $urandom);
                4: set_config(32'd2, 32'd3, $urandom_range(1, 1000), 32'd1000);
                5: set_config(32'd3, 32'd5, ALL_ONES, 32'd1);
                // counts with junk in the upper bits
                6: set_config($urandom, $urandom, $urandom, $urandom_range(1, 5000));
                default: set_config(32'd4, 32'd8, $urandom_range(32'h1_0000, ALL_ONES),
                                    32'd1000);
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < ITEMS_PER_PHASE) begin
                run_episode();
            end
            drain();
        end

        repeat (30) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
